FILE: sv/mhdc2p_pkg.sv
// mhdc2p_pkg: widths, constants and stage types for the conserved-to-primitive block
// used by the channel interfaces and by mhd_conserved_to_primitive
// no dependencies
package mhdc2p_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int GAMMA_W     = 18;
    localparam int QUOT_W      = 48;
    localparam int INT_W       = 48;
    localparam int INT_EXT_W   = 50;
    localparam int MAG_W       = 47;
    localparam int SQ_W        = 64;
    localparam int HALF_W      = 24;
    localparam int DIV_STEPS   = QUOT_W;
    localparam int FIFO_DEPTH  = 2;

    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd43691;

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        word_t       density;
        word_t [2:0] mom;
        word_t [2:0] field;
        word_t       energy;
        logic        last;
    } raw_stage_t;

    typedef struct packed {
        word_t       density;
        word_t [2:0] field;
        word_t       energy;
        logic        last;
        logic        bad;
        logic  [2:0] mom_neg;
        word_t [2:0] mom_abs;
        word_t [2:0] field_abs;
    } abs_stage_t;

    typedef struct packed {
        word_t                 density;
        word_t [2:0]           field;
        word_t                 energy;
        logic                  last;
        logic                  bad;
        logic  [2:0]           mom_neg;
        word_t [2:0]           mom_abs;
        logic  [2:0][SQ_W-1:0] mom_sq;
        logic  [2:0][SQ_W-1:0] field_sq;
    } sq_stage_t;

    typedef struct packed {
        word_t             rem;
        logic [QUOT_W-1:0] dq;
    } div_lane_t;

    typedef struct packed {
        word_t                density;
        word_t [2:0]          field;
        word_t                energy;
        logic                 last;
        logic                 bad;
        logic  [2:0]          mom_neg;
        logic  [MAG_W-1:0]    mag;
        logic                 kin_ovf;
        div_lane_t [2:0]      vel;
        div_lane_t            kin;
    } div_stage_t;

    typedef struct packed {
        word_t             density;
        word_t [2:0]       field;
        logic              last;
        logic              bad;
        word_t [2:0]       vel;
        logic [INT_W-1:0]  internal;
    } fin_stage_t;

    typedef struct packed {
        word_t                       density;
        word_t [2:0]                 field;
        logic                        last;
        logic                        bad;
        word_t [2:0]                 vel;
        logic [HALF_W+GAMMA_W-1:0]   pp_lo;
        logic [HALF_W+GAMMA_W:0]     pp_hi;
    } mul_stage_t;

    typedef struct packed {
        word_t       density;
        word_t [2:0] vel;
        word_t [2:0] field;
        word_t       pressure;
        logic        bad;
        logic        last;
    } result_t;

endpackage

FILE: sv/mhdc2p_if.sv
// mhdc2p_cons_if and mhdc2p_prim_if: valid/ready channels for conserved and primitive items
// depends on mhdc2p_pkg
interface mhdc2p_cons_if
    import mhdc2p_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t in_density;
    word_t in_mom_x;
    word_t in_mom_y;
    word_t in_mom_z;
    word_t in_field_x;
    word_t in_field_y;
    word_t in_field_z;
    word_t in_energy;
    logic  in_last_cell;

    modport source (output valid, in_density, in_mom_x, in_mom_y, in_mom_z, in_field_x,
                    in_field_y, in_field_z, in_energy, in_last_cell, input ready);
    modport sink   (input valid, in_density, in_mom_x, in_mom_y, in_mom_z, in_field_x,
                    in_field_y, in_field_z, in_energy, in_last_cell, output ready);
endinterface

interface mhdc2p_prim_if
    import mhdc2p_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t out_density;
    word_t out_vel_x;
    word_t out_vel_y;
    word_t out_vel_z;
    word_t out_field_x;
    word_t out_field_y;
    word_t out_field_z;
    word_t out_pressure;
    logic  bad_density;
    logic  out_last_cell;

    modport source (output valid, out_density, out_vel_x, out_vel_y, out_vel_z, out_field_x,
                    out_field_y, out_field_z, out_pressure, bad_density, out_last_cell,
                    input ready);
    modport sink   (input valid, out_density, out_vel_x, out_vel_y, out_vel_z, out_field_x,
                    out_field_y, out_field_z, out_pressure, bad_density, out_last_cell,
                    output ready);
endinterface

FILE: sv/mhd_conserved_to_primitive.sv
// mhd_conserved_to_primitive: ideal-MHD conserved-to-primitive conversion, one cell per item
// depends on mhdc2p_pkg and the channel interfaces in mhdc2p_if.sv
//
// Takes one cell per clock while the output queue has room, and returns density, velocity,
// field and gas pressure for it; the throughput is then one item per cycle. Each cell goes
// through the three velocity dividers and the kinetic energy divider, each a 48-stage
// restoring divider retiring one quotient bit per stage, on its way to the output queue.
// A two-entry output queue lets the pipeline keep taking items while a result waits; cons
// stalls only once that queue is full. gamma_minus_one resets to about 2/3 and may be
// rewritten through cfg_wr_en / cfg_wr_data only while no item is in flight.
module mhd_conserved_to_primitive
    import mhdc2p_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    mhdc2p_cons_if.sink         cons,
    mhdc2p_prim_if.source       prim,
    input  logic                cfg_wr_en,
    input  logic [GAMMA_W-1:0]  cfg_wr_data
);

    function automatic div_lane_t div_step(input div_lane_t lane, input word_t d);
        logic [DATA_W:0] rem_sh;
        logic [DATA_W:0] diff;
        logic            ge;
        div_lane_t       r;
        rem_sh = {lane.rem, lane.dq[QUOT_W-1]};
        diff   = rem_sh - {1'b0, d};
        ge     = rem_sh >= {1'b0, d};
        r.rem  = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        r.dq   = {lane.dq[QUOT_W-2:0], ge};
        return r;
    endfunction

    function automatic word_t abs32(input word_t x);
        return x[DATA_W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic word_t vel_sat(input logic [QUOT_W-1:0] q, input logic neg);
        logic over_pos;
        logic over_neg;
        over_pos = (|q[QUOT_W-1:DATA_W-1]);
        over_neg = (|q[QUOT_W-1:DATA_W]) || (q[DATA_W-1] && (|q[DATA_W-2:0]));
        if (neg)
        begin
            return over_neg ? {1'b1, {(DATA_W-1){1'b0}}} : (~q[DATA_W-1:0] + 1'b1);
        end
        return over_pos ? {1'b0, {(DATA_W-1){1'b1}}} : q[DATA_W-1:0];
    endfunction

    logic [GAMMA_W-1:0] gamma_reg;
    logic               en;

    logic               v0_reg, v1_reg, v2_reg, v4_reg, v5_reg;
    raw_stage_t         p0_reg, p0_next;
    abs_stage_t         p1_reg, p1_next;
    sq_stage_t          p2_reg, p2_next;
    logic               dv_reg [DIV_STEPS+1];
    div_stage_t         div_reg [DIV_STEPS+1];
    div_stage_t         div_next [DIV_STEPS+1];
    fin_stage_t         p4_reg, p4_next;
    mul_stage_t         p5_reg, p5_next;
    result_t            res_next;

    result_t            fifo_reg [FIFO_DEPTH];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         count_reg;
    logic               push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RESET;
        end
        else if (cfg_wr_en)
        begin
            gamma_reg <= cfg_wr_data;
        end
    end

    assign en         = (count_reg != 2'(FIFO_DEPTH));
    assign cons.ready = en;

    // stage 0: capture
    always_comb
    begin
        p0_next.density = cons.in_density;
        p0_next.mom     = {cons.in_mom_z, cons.in_mom_y, cons.in_mom_x};
        p0_next.field   = {cons.in_field_z, cons.in_field_y, cons.in_field_x};
        p0_next.energy  = cons.in_energy;
        p0_next.last    = cons.in_last_cell;
    end

    // stage 1: magnitudes
    always_comb
    begin
        p1_next.density = p0_reg.density;
        p1_next.field   = p0_reg.field;
        p1_next.energy  = p0_reg.energy;
        p1_next.last    = p0_reg.last;
        p1_next.bad     = p0_reg.density[DATA_W-1] || (p0_reg.density == '0);
        for (int i = 0; i < 3; i++)
        begin
            p1_next.mom_neg[i]   = p0_reg.mom[i][DATA_W-1];
            p1_next.mom_abs[i]   = abs32(p0_reg.mom[i]);
            p1_next.field_abs[i] = abs32(p0_reg.field[i]);
        end
    end

    // stage 2: squares
    always_comb
    begin
        p2_next.density = p1_reg.density;
        p2_next.field   = p1_reg.field;
        p2_next.energy  = p1_reg.energy;
        p2_next.last    = p1_reg.last;
        p2_next.bad     = p1_reg.bad;
        p2_next.mom_neg = p1_reg.mom_neg;
        p2_next.mom_abs = p1_reg.mom_abs;
        for (int i = 0; i < 3; i++)
        begin
            p2_next.mom_sq[i]   = p1_reg.mom_abs[i] * p1_reg.mom_abs[i];
            p2_next.field_sq[i] = p1_reg.field_abs[i] * p1_reg.field_abs[i];
        end
    end

    // stage 3: sums and divider setup
    always_comb
    begin
        logic [SQ_W-1:0] ksum;
        logic [SQ_W-1:0] bsum;
        ksum = p2_reg.mom_sq[0] + p2_reg.mom_sq[1] + p2_reg.mom_sq[2];
        bsum = p2_reg.field_sq[0] + p2_reg.field_sq[1] + p2_reg.field_sq[2];
        div_next[0].density = p2_reg.density;
        div_next[0].field   = p2_reg.field;
        div_next[0].energy  = p2_reg.energy;
        div_next[0].last    = p2_reg.last;
        div_next[0].bad     = p2_reg.bad;
        div_next[0].mom_neg = p2_reg.mom_neg;
        div_next[0].mag     = bsum[SQ_W-1:SQ_W-MAG_W];
        div_next[0].kin_ovf = {16'b0, ksum[SQ_W-1:QUOT_W]}
                              >= {p2_reg.density[DATA_W-2:0], 1'b0};
        for (int i = 0; i < 3; i++)
        begin
            div_next[0].vel[i].rem = '0;
            div_next[0].vel[i].dq  = {p2_reg.mom_abs[i], {FRAC_W{1'b0}}};
        end
        div_next[0].kin.rem = {16'b0, ksum[SQ_W-1:QUOT_W]};
        div_next[0].kin.dq  = ksum[QUOT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg     <= p0_next;
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
            div_reg[0] <= div_next[0];
            p4_reg     <= p4_next;
            p5_reg     <= p5_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= cons.valid;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
            v4_reg    <= dv_reg[DIV_STEPS];
            v5_reg    <= v4_reg;
        end
    end

    // restoring dividers, one quotient bit per stage
    for (genvar s = 1; s <= DIV_STEPS; s++)
    begin : g_div
        always_comb
        begin
            div_next[s] = div_reg[s-1];
            for (int i = 0; i < 3; i++)
            begin
                div_next[s].vel[i] = div_step(div_reg[s-1].vel[i], div_reg[s-1].density);
            end
            div_next[s].kin = div_step(div_reg[s-1].kin,
                                       {div_reg[s-1].density[DATA_W-2:0], 1'b0});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[s] <= div_next[s];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[s] <= dv_reg[s-1];
            end
        end
    end

    // stage 4: velocity saturation and internal energy
    always_comb
    begin
        logic [INT_EXT_W-1:0] ie;
        div_stage_t           d;
        d  = div_reg[DIV_STEPS];
        ie = {{(INT_EXT_W-DATA_W){d.energy[DATA_W-1]}}, d.energy}
             - {{(INT_EXT_W-QUOT_W){1'b0}}, d.kin.dq}
             - {{(INT_EXT_W-MAG_W){1'b0}}, d.mag};
        p4_next.density = d.density;
        p4_next.field   = d.field;
        p4_next.last    = d.last;
        p4_next.bad     = d.bad;
        for (int i = 0; i < 3; i++)
        begin
            p4_next.vel[i] = d.bad ? '0 : vel_sat(d.vel[i].dq, d.mom_neg[i]);
        end
        if (d.kin_ovf || (ie[INT_EXT_W-1] && !(&ie[INT_EXT_W-2:INT_W-1])))
        begin
            p4_next.internal = {1'b1, {(INT_W-1){1'b0}}};
        end
        else if (!ie[INT_EXT_W-1] && (|ie[INT_EXT_W-2:INT_W-1]))
        begin
            p4_next.internal = {1'b0, {(INT_W-1){1'b1}}};
        end
        else
        begin
            p4_next.internal = ie[INT_W-1:0];
        end
    end

    // stage 5: partial products of internal energy and gamma - 1
    always_comb
    begin
        logic signed [HALF_W-1:0] hi_s;
        logic signed [GAMMA_W:0]  g_s;
        hi_s = p4_reg.internal[INT_W-1:HALF_W];
        g_s  = {1'b0, gamma_reg};
        p5_next.density = p4_reg.density;
        p5_next.field   = p4_reg.field;
        p5_next.last    = p4_reg.last;
        p5_next.bad     = p4_reg.bad;
        p5_next.vel     = p4_reg.vel;
        p5_next.pp_lo   = p4_reg.internal[HALF_W-1:0] * gamma_reg;
        p5_next.pp_hi   = hi_s * g_s;
    end

    // stage 6: pressure and saturation
    always_comb
    begin
        logic signed [INT_W+GAMMA_W:0] prod;
        logic signed [INT_W+GAMMA_W:0] pf;
        logic                          over_pos;
        logic                          over_neg;
        prod = ($signed({{(INT_W-HALF_W){p5_reg.pp_hi[HALF_W+GAMMA_W]}}, p5_reg.pp_hi})
                <<< HALF_W)
               + $signed({{(INT_W-HALF_W+1){1'b0}}, p5_reg.pp_lo});
        pf   = prod >>> FRAC_W;
        over_pos = !pf[INT_W+GAMMA_W] && (|pf[INT_W+GAMMA_W-1:DATA_W-1]);
        over_neg =  pf[INT_W+GAMMA_W] && !(&pf[INT_W+GAMMA_W-1:DATA_W-1]);
        res_next.density = p5_reg.density;
        res_next.field   = p5_reg.field;
        res_next.vel     = p5_reg.vel;
        res_next.bad     = p5_reg.bad;
        res_next.last    = p5_reg.last;
        if (p5_reg.bad)
        begin
            res_next.pressure = '0;
        end
        else if (over_pos)
        begin
            res_next.pressure = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (over_neg)
        begin
            res_next.pressure = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            res_next.pressure = pf[DATA_W-1:0];
        end
    end

    // output queue
    assign push = en && v5_reg;
    assign pop  = prim.valid && prim.ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign prim.valid         = (count_reg != '0);
    assign prim.out_density   = fifo_reg[rd_ptr_reg].density;
    assign prim.out_vel_x     = fifo_reg[rd_ptr_reg].vel[0];
    assign prim.out_vel_y     = fifo_reg[rd_ptr_reg].vel[1];
    assign prim.out_vel_z     = fifo_reg[rd_ptr_reg].vel[2];
    assign prim.out_field_x   = fifo_reg[rd_ptr_reg].field[0];
    assign prim.out_field_y   = fifo_reg[rd_ptr_reg].field[1];
    assign prim.out_field_z   = fifo_reg[rd_ptr_reg].field[2];
    assign prim.out_pressure  = fifo_reg[rd_ptr_reg].pressure;
    assign prim.bad_density   = fifo_reg[rd_ptr_reg].bad;
    assign prim.out_last_cell = fifo_reg[rd_ptr_reg].last;

endmodule

FILE: sv/mhdc2p_checker.sv
// mhdc2p_checker: port-level assertions for mhd_conserved_to_primitive, with its bind
// depends on mhdc2p_pkg and the top level's ports
module mhdc2p_checker
    import mhdc2p_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  valid,
    input logic  ready,
    input word_t out_density,
    input word_t out_vel_x,
    input word_t out_vel_y,
    input word_t out_vel_z,
    input word_t out_pressure,
    input logic  bad_density
);

    // a stalled item stays put
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(out_density) && $stable(out_pressure)
                            && $stable(bad_density))
        else $error("result item changed while stalled");

    // flag agrees with the density that travels with it
    a_bad_flag: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> bad_density == (out_density[DATA_W-1] || (out_density == '0)))
        else $error("bad density flag disagrees with density");

    // flagged item carries zero velocity and pressure
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && bad_density |-> (out_vel_x == '0) && (out_vel_y == '0)
                                 && (out_vel_z == '0) && (out_pressure == '0))
        else $error("flagged item has nonzero velocity or pressure");

endmodule

bind mhd_conserved_to_primitive mhdc2p_checker u_mhdc2p_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (prim.valid),
    .ready        (prim.ready),
    .out_density  (prim.out_density),
    .out_vel_x    (prim.out_vel_x),
    .out_vel_y    (prim.out_vel_y),
    .out_vel_z    (prim.out_vel_z),
    .out_pressure (prim.out_pressure),
    .bad_density  (prim.bad_density)
);
